[hw/rtl/rrf_pkg.sv]
// Shared types and constants for the register rename unit.
// Holds the request and response structs, the operation codes and the
// internal write-port structs. Depends on nothing.
`default_nettype none

package rrf_pkg;

    localparam int ARCH_REGISTERS = 32;
    localparam int WINDOW_ENTRIES = 512;
    localparam int PHYS_REGS      = ARCH_REGISTERS + WINDOW_ENTRIES;
    localparam int ARCH_W         = $clog2(ARCH_REGISTERS);
    localparam int PHYS_W         = $clog2(PHYS_REGS);
    localparam int FIELD_W        = 10;
    localparam int ARCH_FIELD_W   = 5;
    localparam int OQ_DEPTH       = 4;
    localparam int OQ_PW          = $clog2(OQ_DEPTH);
    localparam int OQ_W           = $clog2(OQ_DEPTH + 1);

    localparam logic [FIELD_W-1:0] NO_DEST    = FIELD_W'(PHYS_REGS);
    localparam logic [FIELD_W-1:0] PHYS_LIMIT = FIELD_W'(PHYS_REGS);

    typedef enum logic [1:0] {
        OP_RENAME     = 2'd0,
        OP_MARK_READY = 2'd1,
        OP_CHECK      = 2'd2
    } t_op;

    typedef struct packed {
        logic [1:0]              operation;
        logic [ARCH_FIELD_W-1:0] source_a;
        logic [ARCH_FIELD_W-1:0] source_b;
        logic [ARCH_FIELD_W-1:0] dest_arch;
        logic                    has_dest;
        logic [FIELD_W-1:0]      query_phys_a;
        logic [FIELD_W-1:0]      query_phys_b;
    } t_req;

    typedef struct packed {
        logic [FIELD_W-1:0] mapped_a;
        logic [FIELD_W-1:0] mapped_b;
        logic [FIELD_W-1:0] mapped_dest;
        logic               ready_a;
        logic               ready_b;
    } t_resp;

    typedef struct packed {
        logic              vld;
        logic [ARCH_W-1:0] addr;
        logic [PHYS_W-1:0] data;
    } t_map_wr;

    typedef struct packed {
        logic              vld;
        logic [PHYS_W-1:0] addr;
        logic              val;
    } t_rdy_wr;

    typedef struct packed {
        logic              vld;
        logic [PHYS_W-1:0] addr;
        logic [PHYS_W-1:0] data;
    } t_fl_init;

    typedef struct packed {
        logic              push;
        logic [PHYS_W-1:0] push_data;
        logic              pop;
    } t_fl_ctl;

endpackage

`default_nettype wire

[hw/rtl/rrf_map.sv]
// Architectural-to-physical rename map with registered reads.
// Two identical copies give three read ports with one write port.
// Depends on rrf_pkg.
`default_nettype none

module rrf_map (
    input  wire                         i_clk,
    input  wire rrf_pkg::t_map_wr       i_wr,
    input  wire [rrf_pkg::ARCH_W-1:0]   i_rd_a,
    input  wire [rrf_pkg::ARCH_W-1:0]   i_rd_b,
    input  wire [rrf_pkg::ARCH_W-1:0]   i_rd_d,
    output logic [rrf_pkg::PHYS_W-1:0]  o_a,
    output logic [rrf_pkg::PHYS_W-1:0]  o_b,
    output logic [rrf_pkg::PHYS_W-1:0]  o_d
);
    import rrf_pkg::*;

    logic [PHYS_W-1:0] r_map0 [ARCH_REGISTERS];
    logic [PHYS_W-1:0] r_map1 [ARCH_REGISTERS];
    logic [PHYS_W-1:0] r_a;
    logic [PHYS_W-1:0] r_b;
    logic [PHYS_W-1:0] r_d;

    always_ff @(posedge i_clk) begin
        if (i_wr.vld) begin
            r_map0[i_wr.addr] <= i_wr.data;
            r_map1[i_wr.addr] <= i_wr.data;
        end
        r_a <= r_map0[i_rd_a];
        r_d <= r_map0[i_rd_d];
        r_b <= r_map1[i_rd_b];
    end

    assign o_a = r_a;
    assign o_b = r_b;
    assign o_d = r_d;

endmodule

`default_nettype wire

[hw/rtl/rrf_free_list.sv]
// Circular free list of physical registers with its read and write pointers.
// The head entry is prefetched into a register ahead of its use.
// Depends on rrf_pkg.
`default_nettype none

module rrf_free_list (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire rrf_pkg::t_fl_init      i_init,
    input  wire rrf_pkg::t_fl_ctl       i_ctl,
    output logic [rrf_pkg::PHYS_W-1:0]  o_head,
    output logic                        o_empty
);
    import rrf_pkg::*;

    logic [PHYS_W-1:0] r_fifo [PHYS_REGS];
    logic [PHYS_W-1:0] r_rd;
    logic [PHYS_W-1:0] r_wr;
    logic [PHYS_W-1:0] r_head;
    logic [PHYS_W-1:0] n_rd;
    logic [PHYS_W-1:0] n_wr;

    function automatic logic [PHYS_W-1:0] ptr_inc(input logic [PHYS_W-1:0] p);
        ptr_inc = (p == PHYS_W'(PHYS_REGS - 1)) ? '0 : p + PHYS_W'(1);
    endfunction

    always_comb begin
        n_rd = i_ctl.pop  ? ptr_inc(r_rd) : r_rd;
        n_wr = i_ctl.push ? ptr_inc(r_wr) : r_wr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd <= '0;
            r_wr <= PHYS_W'(WINDOW_ENTRIES);
        end else begin
            r_rd <= n_rd;
            r_wr <= n_wr;
        end
    end

    // The slot written by a push is never the next head: the list always
    // holds many more entries than one.
    always_ff @(posedge i_clk) begin
        if (i_init.vld) begin
            r_fifo[i_init.addr] <= i_init.data;
        end else if (i_ctl.push) begin
            r_fifo[r_wr] <= i_ctl.push_data;
        end
        r_head <= r_fifo[n_rd];
    end

    assign o_head  = r_head;
    assign o_empty = (r_rd == r_wr);

endmodule

`default_nettype wire

[hw/rtl/rrf_ready.sv]
// Ready scoreboard: one bit per physical register.
// One write port and two registered read ports. Depends on rrf_pkg.
`default_nettype none

module rrf_ready (
    input  wire                         i_clk,
    input  wire rrf_pkg::t_rdy_wr       i_wr,
    input  wire [rrf_pkg::PHYS_W-1:0]   i_rd_a,
    input  wire [rrf_pkg::PHYS_W-1:0]   i_rd_b,
    output logic                        o_a,
    output logic                        o_b
);
    import rrf_pkg::*;

    logic r_bits [PHYS_REGS];
    logic r_a;
    logic r_b;

    always_ff @(posedge i_clk) begin
        if (i_wr.vld) begin
            r_bits[i_wr.addr] <= i_wr.val;
        end
        r_a <= r_bits[i_rd_a];
        r_b <= r_bits[i_rd_b];
    end

    assign o_a = r_a;
    assign o_b = r_b;

endmodule

`default_nettype wire

[hw/rtl/rrf_out_queue.sv]
// Small response queue in front of the output channel.
// Its space is reserved when a request is accepted. Depends on rrf_pkg.
`default_nettype none

module rrf_out_queue (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_push,
    input  wire rrf_pkg::t_resp     i_data,
    input  wire                     i_pop,
    output logic                    o_valid,
    output rrf_pkg::t_resp          o_data,
    output logic                    o_full
);
    import rrf_pkg::*;

    t_resp            r_mem [OQ_DEPTH];
    logic [OQ_PW-1:0] r_wp;
    logic [OQ_PW-1:0] r_rp;
    logic [OQ_W-1:0]  r_cnt;
    logic [OQ_W-1:0]  n_cnt;

    function automatic logic [OQ_PW-1:0] qp_inc(input logic [OQ_PW-1:0] p);
        qp_inc = (p == OQ_PW'(OQ_DEPTH - 1)) ? '0 : p + OQ_PW'(1);
    endfunction

    always_comb begin
        n_cnt = r_cnt + OQ_W'(i_push) - OQ_W'(i_pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= qp_inc(r_wp);
            end
            if (i_pop) begin
                r_rp <= qp_inc(r_rp);
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign o_full  = (r_cnt == OQ_W'(OQ_DEPTH));

endmodule

`default_nettype wire

[hw/rtl/register_rename_free_list_scoreboard_unit.sv]
// Top level of the register rename unit: map, free list, ready scoreboard.
// Instantiates rrf_map, rrf_free_list, rrf_ready and rrf_out_queue; uses rrf_pkg.
`default_nettype none

// The unit takes one request per clock cycle while it does not stall its input
// and gives one response for each request, in order. A rename request looks up
// both sources in the rename map and reports their physical registers with their
// ready bits; if it has a destination, the old mapping goes back onto the free
// list, a fresh register is taken from its head, marked not ready and entered in
// the map. A mark-ready request sets one ready bit and a check request reports
// two. A request is registered at acceptance together with the map read data,
// is completed in the following cycle, where the map, free list and ready bits
// are updated, has its ready bits read into the second stage and then enters a
// four-entry response queue, from which the response is taken. Requests flow at
// one per cycle for as long as the output side keeps taking responses; outside
// the clearing pass the input stalls only when four requests are outstanding.
// After reset the unit runs a clearing pass that visits each physical register
// once, loads the map, the ready bits and the free list, and holds its input
// stalled until that pass is over.

module register_rename_free_list_scoreboard_unit (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire rrf_pkg::t_req  i_req,
    output logic                o_valid,
    input  wire                 i_stall,
    output rrf_pkg::t_resp      o_resp
);
    import rrf_pkg::*;

    // Clearing pass after reset.
    logic              r_init_busy;
    logic [PHYS_W-1:0] r_init_idx;

    // Handshakes and count of requests accepted but not yet delivered.
    logic              acc;
    logic              del;
    logic [OQ_W-1:0]   r_count;

    // First stage: the request with its map read data.
    logic              r_s1_vld;
    t_req              r_s1_req;
    t_map_wr           r_fwd;

    logic [PHYS_W-1:0] map_a;
    logic [PHYS_W-1:0] map_b;
    logic [PHYS_W-1:0] map_d;
    logic [PHYS_W-1:0] ma;
    logic [PHYS_W-1:0] mb;
    logic [PHYS_W-1:0] old_d;
    logic [PHYS_W-1:0] fl_head;
    logic              fl_empty;

    logic              is_ren;
    logic              is_mark;
    logic              is_chk;
    logic              alloc;
    logic              qa_in;
    logic              qb_in;

    t_map_wr           map_wr;
    t_rdy_wr           rdy_wr;
    t_fl_init          fl_init;
    t_fl_ctl           fl_ctl;
    logic [PHYS_W-1:0] rdy_addr_a;
    logic [PHYS_W-1:0] rdy_addr_b;
    t_resp             s1_resp;
    logic              s1_use_a;
    logic              s1_use_b;

    // Second stage: ready bits arrive from the scoreboard.
    logic              r_s2_vld;
    t_resp             r_s2_resp;
    logic              r_s2_use_a;
    logic              r_s2_use_b;
    logic              rdy_q_a;
    logic              rdy_q_b;
    t_resp             q_in;
    logic              q_full;

    // ------------------------------------------------------------------
    // Handshakes. Space in the response queue is reserved at acceptance, so
    // nothing inside the pipeline ever has to wait.
    // ------------------------------------------------------------------
    assign o_stall = r_init_busy || (r_count == OQ_W'(OQ_DEPTH));
    assign acc     = i_valid && !o_stall;
    assign del     = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= r_count + OQ_W'(acc) - OQ_W'(del);
        end
    end

    // The clearing pass walks every physical register once.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_busy <= 1'b1;
            r_init_idx  <= '0;
        end else if (r_init_busy) begin
            r_init_idx <= r_init_idx + PHYS_W'(1);
            if (r_init_idx == PHYS_W'(PHYS_REGS - 1)) begin
                r_init_busy <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage one. The map is read at the accepting edge straight from the
    // request fields. The request ahead may write the map at that same edge,
    // which the read does not see, so that write is registered and forwarded.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_fwd    <= '0;
        end else begin
            r_s1_vld <= acc;
            r_fwd    <= map_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_req <= i_req;
    end

    rrf_map u_map (
        .i_clk  (i_clk),
        .i_wr   (map_wr),
        .i_rd_a (i_req.source_a[ARCH_W-1:0]),
        .i_rd_b (i_req.source_b[ARCH_W-1:0]),
        .i_rd_d (i_req.dest_arch[ARCH_W-1:0]),
        .o_a    (map_a),
        .o_b    (map_b),
        .o_d    (map_d)
    );

    always_comb begin
        ma    = (r_fwd.vld && r_fwd.addr == r_s1_req.source_a[ARCH_W-1:0])
                ? r_fwd.data : map_a;
        mb    = (r_fwd.vld && r_fwd.addr == r_s1_req.source_b[ARCH_W-1:0])
                ? r_fwd.data : map_b;
        old_d = (r_fwd.vld && r_fwd.addr == r_s1_req.dest_arch[ARCH_W-1:0])
                ? r_fwd.data : map_d;
        qa_in = (r_s1_req.query_phys_a < PHYS_LIMIT);
        qb_in = (r_s1_req.query_phys_b < PHYS_LIMIT);
    end

    // Operation decode. The unused code changes nothing and reports the
    // empty response.
    always_comb begin
        is_ren  = 1'b0;
        is_mark = 1'b0;
        is_chk  = 1'b0;
        if (r_s1_vld) begin
            unique case (r_s1_req.operation)
                OP_RENAME:     is_ren  = 1'b1;
                OP_MARK_READY: is_mark = 1'b1;
                OP_CHECK:      is_chk  = 1'b1;
                default:       ;
            endcase
        end
        alloc = is_ren && r_s1_req.has_dest;
    end

    // State updates. During the clearing pass the same write ports load the
    // reset contents; no request is in flight then.
    always_comb begin
        map_wr  = '0;
        rdy_wr  = '0;
        fl_init = '0;
        fl_ctl  = '0;
        if (r_init_busy) begin
            if (r_init_idx < PHYS_W'(ARCH_REGISTERS)) begin
                map_wr.vld  = 1'b1;
                map_wr.addr = r_init_idx[ARCH_W-1:0];
                map_wr.data = r_init_idx;
            end
            rdy_wr.vld   = 1'b1;
            rdy_wr.addr  = r_init_idx;
            rdy_wr.val   = (r_init_idx < PHYS_W'(ARCH_REGISTERS));
            fl_init.vld  = 1'b1;
            fl_init.addr = r_init_idx;
            fl_init.data = (r_init_idx < PHYS_W'(WINDOW_ENTRIES))
                           ? r_init_idx + PHYS_W'(ARCH_REGISTERS) : '0;
        end else if (alloc) begin
            // The old mapping is released and the head of the free list
            // taken in the same cycle; the new register starts not ready.
            map_wr.vld       = 1'b1;
            map_wr.addr      = r_s1_req.dest_arch[ARCH_W-1:0];
            map_wr.data      = fl_head;
            rdy_wr.vld       = 1'b1;
            rdy_wr.addr      = fl_head;
            rdy_wr.val       = 1'b0;
            fl_ctl.push      = 1'b1;
            fl_ctl.push_data = old_d;
            fl_ctl.pop       = 1'b1;
        end else if (is_mark && qa_in) begin
            // A writeback to a register beyond the file is ignored.
            rdy_wr.vld  = 1'b1;
            rdy_wr.addr = PHYS_W'(r_s1_req.query_phys_a);
            rdy_wr.val  = 1'b1;
        end
    end

    rrf_free_list u_free_list (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_init  (fl_init),
        .i_ctl   (fl_ctl),
        .o_head  (fl_head),
        .o_empty (fl_empty)
    );

    // Ready reads are issued at the end of stage one, so they see every
    // earlier update but not this request's own clearing of its new register.
    always_comb begin
        rdy_addr_a = '0;
        rdy_addr_b = '0;
        if (is_ren) begin
            rdy_addr_a = ma;
            rdy_addr_b = mb;
        end else if (is_chk) begin
            if (qa_in) begin
                rdy_addr_a = PHYS_W'(r_s1_req.query_phys_a);
            end
            if (qb_in) begin
                rdy_addr_b = PHYS_W'(r_s1_req.query_phys_b);
            end
        end
        s1_use_a = is_ren || (is_chk && qa_in);
        s1_use_b = is_ren || (is_chk && qb_in);

        s1_resp             = '0;
        s1_resp.mapped_dest = NO_DEST;
        if (is_ren) begin
            s1_resp.mapped_a = FIELD_W'(ma);
            s1_resp.mapped_b = FIELD_W'(mb);
        end
        if (alloc) begin
            s1_resp.mapped_dest = FIELD_W'(fl_head);
        end
    end

    rrf_ready u_ready (
        .i_clk  (i_clk),
        .i_wr   (rdy_wr),
        .i_rd_a (rdy_addr_a),
        .i_rd_b (rdy_addr_b),
        .o_a    (rdy_q_a),
        .o_b    (rdy_q_b)
    );

    // ------------------------------------------------------------------
    // Stage two: merge the ready bits and write the response queue.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_vld <= 1'b0;
        end else begin
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_resp  <= s1_resp;
        r_s2_use_a <= s1_use_a;
        r_s2_use_b <= s1_use_b;
    end

    always_comb begin
        q_in         = r_s2_resp;
        q_in.ready_a = r_s2_use_a && rdy_q_a;
        q_in.ready_b = r_s2_use_b && rdy_q_b;
    end

    rrf_out_queue u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s2_vld),
        .i_data  (q_in),
        .i_pop   (del),
        .o_valid (o_valid),
        .o_data  (o_resp),
        .o_full  (q_full)
    );

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= OQ_W'(OQ_DEPTH))
        else $error("outstanding request count exceeds the response queue");

    a_queue_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s2_vld |-> !q_full)
        else $error("response written into a full queue");

    a_free_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alloc |-> !fl_empty)
        else $error("allocation from an empty free list");

    a_fresh_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        alloc |-> (fl_head < PHYS_W'(PHYS_REGS)))
        else $error("free list returned a register beyond the file");

endmodule

`default_nettype wire

[test/tb.sv]
// Self-checking bench for register_rename_free_list_scoreboard_unit.
// Drives a table of directed requests and then random ones, and checks every
// response against a given value or a rename-map, free-list and ready-bit model.
// Depends on rrf_pkg and register_rename_free_list_scoreboard_unit.
`timescale 1ns / 1ps

module tb;
    import rrf_pkg::*;

    // The unit has no code 3. It must still answer with an empty response and
    // leave its state alone.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int RANDOM_REQUESTS = 628;
    localparam int PHASE_LEN       = RANDOM_REQUESTS / 4;
    localparam int RECENT_DEPTH    = 16;
    localparam int LONG_HOLD       = 64;
    localparam int DRAIN_CYCLES    = 10;
    // The clearing pass after reset accepts nothing.
    // The long receiver hold and the random gaps are far shorter than that pass.
    localparam int WATCHDOG_LIMIT  = 2000;

    // Every field zero except the destination, which reads as "none".
    localparam t_resp QUIET_RESP = '{
        mapped_a: '0, mapped_b: '0, mapped_dest: NO_DEST, ready_a: 1'b0, ready_b: 1'b0
    };

    typedef struct {
        t_req  req;
        bit    typed;
        t_resp want;
    } t_directed_row;

    logic  i_clk   = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  i_stall = 1'b0;
    t_req  i_req   = '0;
    logic  o_stall;
    logic  o_valid;
    t_resp o_resp;

    // This copy of the unit's state is advanced once for every accepted request.
    logic [FIELD_W-1:0] arch_to_phys [ARCH_REGISTERS];
    bit                 phys_ready   [PHYS_REGS];
    logic [FIELD_W-1:0] free_slots   [PHYS_REGS];
    int                 free_head;
    int                 free_tail;

    // Responses owed by the unit, oldest first.
    t_resp              rename_results_due [$];
    // Registers handed out lately. Mark and check requests mostly aim here, so
    // the ready bits of live registers keep changing.
    logic [FIELD_W-1:0] recent_phys [$];
    t_directed_row      directed_rows [$];

    int mismatches         = 0;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int hold_left          = 0;
    int quiet_cycles       = 0;
    bit hold_requested     = 1'b0;

    register_rename_free_list_scoreboard_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_req   (i_req),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_resp  (o_resp)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Registers outside the physical file read as not ready.
    function automatic bit phys_is_ready(input logic [FIELD_W-1:0] p);
        return (p < PHYS_LIMIT) ? phys_ready[p] : 1'b0;
    endfunction

    // Works out the response to one request and applies the request to the
    // model state. On a rename, both ready bits are read before the
    // destination is updated. The old mapping goes back onto the free list
    // before the fresh register is taken from its head.
    function automatic t_resp compute_rename_response(input t_req r);
        t_resp              rsp;
        logic [FIELD_W-1:0] fresh;
        int                 next_tail;
        rsp = QUIET_RESP;
        case (r.operation)
            OP_RENAME: begin
                rsp.mapped_a = arch_to_phys[r.source_a];
                rsp.mapped_b = arch_to_phys[r.source_b];
                rsp.ready_a  = phys_is_ready(rsp.mapped_a);
                rsp.ready_b  = phys_is_ready(rsp.mapped_b);
                if (r.has_dest) begin
                    next_tail = (free_tail + 1) % PHYS_REGS;
                    // A push onto a full list is dropped.
                    if (next_tail != free_head) begin
                        free_slots[free_tail] = arch_to_phys[r.dest_arch];
                        free_tail             = next_tail;
                    end
                    // An empty list allocates nothing and leaves the map alone.
                    if (free_head != free_tail) begin
                        fresh     = free_slots[free_head];
                        free_head = (free_head + 1) % PHYS_REGS;
                        if (fresh < PHYS_LIMIT)
                            phys_ready[fresh] = 1'b0;
                        arch_to_phys[r.dest_arch] = fresh;
                        rsp.mapped_dest           = fresh;
                    end
                end
            end
            OP_MARK_READY: begin
                if (r.query_phys_a < PHYS_LIMIT)
                    phys_ready[r.query_phys_a] = 1'b1;
            end
            OP_CHECK: begin
                rsp.ready_a = phys_is_ready(r.query_phys_a);
                rsp.ready_b = phys_is_ready(r.query_phys_b);
            end
            default: begin
            end
        endcase
        return rsp;
    endfunction

    function automatic t_resp resp_of(input logic [FIELD_W-1:0] ma,
                                      input logic [FIELD_W-1:0] mb,
                                      input logic [FIELD_W-1:0] md,
                                      input logic ra, input logic rb);
        t_resp rsp;
        rsp.mapped_a    = ma;
        rsp.mapped_b    = mb;
        rsp.mapped_dest = md;
        rsp.ready_a     = ra;
        rsp.ready_b     = rb;
        return rsp;
    endfunction

    // A row with typed set is checked against the value given. Any other row
    // is checked against the model.
    function automatic void add_row(input logic [1:0] op,
                                    input logic [ARCH_FIELD_W-1:0] sa,
                                    input logic [ARCH_FIELD_W-1:0] sb,
                                    input logic [ARCH_FIELD_W-1:0] da,
                                    input logic hd,
                                    input logic [FIELD_W-1:0] qa,
                                    input logic [FIELD_W-1:0] qb,
                                    input bit typed, input t_resp want);
        t_directed_row row;
        row.req.operation    = op;
        row.req.source_a     = sa;
        row.req.source_b     = sb;
        row.req.dest_arch    = da;
        row.req.has_dest     = hd;
        row.req.query_phys_a = qa;
        row.req.query_phys_b = qb;
        row.typed            = typed;
        row.want             = want;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [FIELD_W-1:0] pick_phys();
        if (recent_phys.size() != 0 && $urandom_range(99) < 85)
            return recent_phys[$urandom_range(recent_phys.size() - 1)];
        return FIELD_W'($urandom_range(1023));
    endfunction

    // Renames dominate and nearly all carry a destination, so the free list is
    // drawn far into its initial contents.
    // Fields that the operation ignores still carry random values.
    function automatic t_req random_request();
        t_req r;
        int   pick;
        r.source_a     = ARCH_FIELD_W'($urandom_range(31));
        r.source_b     = ARCH_FIELD_W'($urandom_range(31));
        r.dest_arch    = ARCH_FIELD_W'($urandom_range(31));
        r.has_dest     = ($urandom_range(99) < 97);
        r.query_phys_a = FIELD_W'($urandom_range(1023));
        r.query_phys_b = FIELD_W'($urandom_range(1023));
        pick = $urandom_range(99);
        if (pick < 80) begin
            r.operation = OP_RENAME;
        end else if (pick < 90) begin
            r.operation    = OP_MARK_READY;
            r.query_phys_a = pick_phys();
        end else if (pick < 98) begin
            r.operation    = OP_CHECK;
            r.query_phys_a = pick_phys();
            r.query_phys_b = pick_phys();
        end else begin
            r.operation = OP_UNUSED;
        end
        return r;
    endfunction

    // Offers one request and holds it until accepted. The task is entered
    // just after a rising edge. Valid is set at most once per edge, so a
    // request that follows straight on keeps valid high without a glitch.
    task automatic offer(input t_req r, input bit typed, input t_resp want);
        t_resp model_resp;
        while ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        model_resp = compute_rename_response(r);
        if (model_resp.mapped_dest != NO_DEST) begin
            recent_phys.push_back(model_resp.mapped_dest);
            if (recent_phys.size() > RECENT_DEPTH)
                void'(recent_phys.pop_front());
        end
        rename_results_due.push_back(typed ? want : model_resp);
    endtask

    // Receiver. It checks each accepted response against the oldest one
    // owed, then decides whether to stall in the next cycle. A long hold
    // requested by the stimulus is counted down here. While it runs, the
    // unit fills and has to stall its own input.
    always @(posedge i_clk) begin
        t_resp due;
        if (o_valid && !i_stall) begin
            if (rename_results_due.size() == 0) begin
                $error("response with no request outstanding: %p", o_resp);
                mismatches++;
            end else begin
                due = rename_results_due.pop_front();
                if (o_resp.mapped_a !== due.mapped_a) begin
                    $error("mapped_a: expected %0d, got %0d", due.mapped_a, o_resp.mapped_a);
                    mismatches++;
                end
                if (o_resp.mapped_b !== due.mapped_b) begin
                    $error("mapped_b: expected %0d, got %0d", due.mapped_b, o_resp.mapped_b);
                    mismatches++;
                end
                if (o_resp.mapped_dest !== due.mapped_dest) begin
                    $error("mapped_dest: expected %0d, got %0d",
                           due.mapped_dest, o_resp.mapped_dest);
                    mismatches++;
                end
                if (o_resp.ready_a !== due.ready_a) begin
                    $error("ready_a: expected %0d, got %0d", due.ready_a, o_resp.ready_a);
                    mismatches++;
                end
                if (o_resp.ready_b !== due.ready_b) begin
                    $error("ready_b: expected %0d, got %0d", due.ready_b, o_resp.ready_b);
                    mismatches++;
                end
            end
        end
        if (hold_requested) begin
            hold_left      = LONG_HOLD;
            hold_requested = 1'b0;
        end
        if (hold_left > 0)
            hold_left--;
        i_stall <= (hold_left > 0) || ($urandom_range(99) < receiver_stall_pct);
    end

    // Ends the run if neither side moves a request for too long.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int n;
        // The model starts as the unit does after its clearing pass.
        for (n = 0; n < ARCH_REGISTERS; n++)
            arch_to_phys[n] = FIELD_W'(n);
        for (n = 0; n < PHYS_REGS; n++) begin
            phys_ready[n] = (n < ARCH_REGISTERS);
            free_slots[n] = (n < WINDOW_ENTRIES) ? FIELD_W'(ARCH_REGISTERS + n) : '0;
        end
        free_head = 0;
        free_tail = WINDOW_ENTRIES % PHYS_REGS;

        // Directed part. The first rows read the state just after reset.
        // Later rows exercise forwarding, where a rename reads a register that
        // the request before it has just renamed.
        add_row(OP_RENAME, 0, 31, 7, 0, 1023, 1023, 1, resp_of(0, 31, NO_DEST, 1, 1));
        add_row(OP_CHECK, 0, 0, 0, 0, 0, 31, 1, resp_of(0, 0, NO_DEST, 1, 1));
        add_row(OP_CHECK, 0, 0, 0, 0, 32, 543, 1, QUIET_RESP);
        // Physical indexes past the register file read as not ready.
        add_row(OP_CHECK, 0, 0, 0, 0, 544, 1023, 1, QUIET_RESP);
        // Sources equal to the destination report their old mapping and its
        // ready bit. The first allocation is the head of the free list.
        add_row(OP_RENAME, 5, 5, 5, 1, 0, 0, 1, resp_of(5, 5, 32, 1, 1));
        add_row(OP_RENAME, 5, 0, 0, 0, 0, 0, 0, QUIET_RESP);
        add_row(OP_MARK_READY, 0, 0, 0, 0, 32, 0, 1, QUIET_RESP);
        add_row(OP_CHECK, 0, 0, 0, 0, 32, 5, 0, QUIET_RESP);
        // Out-of-range writebacks are ignored.
        add_row(OP_MARK_READY, 31, 31, 31, 1, 1023, 1023, 1, QUIET_RESP);
        add_row(OP_MARK_READY, 0, 0, 0, 0, 544, 0, 1, QUIET_RESP);
        add_row(OP_CHECK, 0, 0, 0, 0, 1023, 544, 1, QUIET_RESP);
        add_row(OP_UNUSED, 31, 31, 31, 1, 1023, 1023, 1, QUIET_RESP);
        add_row(OP_RENAME, 31, 0, 31, 1, 0, 0, 0, QUIET_RESP);
        add_row(OP_RENAME, 31, 31, 0, 1, 0, 0, 0, QUIET_RESP);
        add_row(OP_RENAME, 0, 31, 31, 0, 1023, 1023, 0, QUIET_RESP);
        add_row(OP_CHECK, 0, 0, 0, 0, 33, 34, 0, QUIET_RESP);
        add_row(OP_MARK_READY, 0, 0, 0, 0, 543, 0, 1, QUIET_RESP);
        add_row(OP_CHECK, 0, 0, 0, 0, 543, 0, 0, QUIET_RESP);
        add_row(OP_RENAME, 0, 0, 0, 1, 0, 0, 0, QUIET_RESP);
        add_row(OP_MARK_READY, 0, 0, 0, 0, 0, 0, 1, QUIET_RESP);
        add_row(OP_RENAME, 0, 5, 31, 1, 0, 0, 0, QUIET_RESP);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The unit stalls its input through the clearing pass. The first
        // offer simply waits for it to finish.
        foreach (directed_rows[n])
            offer(directed_rows[n].req, directed_rows[n].typed, directed_rows[n].want);

        // Random part: no idling, a slow sender, a slow receiver, then both.
        for (n = 0; n < RANDOM_REQUESTS; n++) begin
            if (n % PHASE_LEN == 0) begin
                case (n / PHASE_LEN)
                    0: begin
                        sender_idle_pct    = 0;
                        receiver_stall_pct = 0;
                    end
                    1: begin
                        sender_idle_pct    = 57;
                        receiver_stall_pct = 0;
                    end
                    2: begin
                        sender_idle_pct    = 0;
                        receiver_stall_pct = 57;
                    end
                    default: begin
                        sender_idle_pct    = 22;
                        receiver_stall_pct = 22;
                    end
                endcase
            end
            // One long hold while the sender runs flat out, so the response
            // queue fills and the unit backs up onto its input.
            if (n == 40)
                hold_requested = 1'b1;
            offer(random_request(), 1'b0, QUIET_RESP);
        end
        i_valid <= 1'b0;

        while (rename_results_due.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        if (mismatches == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
